>>> src/rbad_pkg.sv
package rbad_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MEM  = 2'd1;
  localparam logic [1:0] OP_IO   = 2'd2;
  localparam logic [1:0] OP_CFG  = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic CFG_MMCFG_BASE = 1'b0;
  localparam logic CFG_LEGACY     = 1'b1;

  localparam logic [3:0]  WIDTH_CODE_LIMIT = 4'd12;
  localparam logic [7:0]  DEV_MAX          = 8'd31;
  localparam logic [7:0]  FUNC_MAX         = 8'd7;
  localparam logic [11:0] LEGACY_REG_MAX   = 12'h0ff;
  localparam logic [11:0] ECAM_REG_MAX     = 12'hfff;
  localparam logic [31:0] CF8_ENABLE       = 32'h8000_0000;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  width_code;
    logic [63:0] bus_address;
    logic [31:0] element_count;
    logic [11:0] element_index;
    logic [2:0]  window_index;
    logic [63:0] window_base;
    logic [63:0] window_limit;
    logic [63:0] window_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] target_address;
    logic        legacy_cycle;
    logic [31:0] cf8_word;
    logic [1:0]  data_port_offset;
  } out_item_t;

  // Classified request handed from the front end to the back end.
  // addr/end_addr/aux carry base/limit/offset for a window load.
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  window_index;
    logic        window_en;
    logic        span_ok;
    logic [1:0]  cfg_status;
    logic        legacy;
    logic [63:0] addr;
    logic [63:0] end_addr;
    logic [63:0] aux;
    logic [31:0] cf8;
    logic [1:0]  port;
  } cmd_t;

endpackage

>>> src/rbad_front.sv
module rbad_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rbad_pkg::in_item_t in_data,
  input  logic              legacy_mode,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output rbad_pkg::cmd_t    cmd_data
);

  logic           valid_r;
  logic           valid_nxt;
  rbad_pkg::cmd_t cmd_r;
  rbad_pkg::cmd_t cmd_nxt;
  logic           accept;

  logic [1:0]  sh;
  logic        code_bad;
  logic        is_fifo;
  logic [7:0]  cfg_reg;
  logic [7:0]  cfg_func;
  logic [7:0]  cfg_dev;
  logic [7:0]  cfg_bus;
  logic [31:0] cfg_ext;
  logic [31:0] cfg_off;
  logic [63:0] span_base;
  logic [31:0] elements;
  logic [34:0] span_m1;
  logic [64:0] end_sum;
  logic [2:0]  align_mask;
  logic        misalign;
  logic        span_ok;
  logic [11:0] reg_max;
  logic        too_high;
  logic        pre_invalid;
  logic        elem_bad;
  logic [11:0] elem_sel;
  logic [14:0] elem_step;
  logic [7:0]  low8;
  logic [1:0]  cfg_status;

  assign accept   = in_valid && !in_stall;
  assign in_stall = valid_r && !cmd_ready;

  always_comb begin
    sh        = in_data.width_code[1:0];
    code_bad  = in_data.width_code >= rbad_pkg::WIDTH_CODE_LIMIT;
    is_fifo   = in_data.width_code[3:2] == 2'b01;
    cfg_reg   = in_data.bus_address[7:0];
    cfg_func  = in_data.bus_address[15:8];
    cfg_dev   = in_data.bus_address[23:16];
    cfg_bus   = in_data.bus_address[31:24];
    cfg_ext   = in_data.bus_address[63:32];
    cfg_off   = (cfg_ext != 32'd0) ? cfg_ext : {24'd0, cfg_reg};
    span_base = (in_data.op == rbad_pkg::OP_CFG) ? {32'd0, cfg_off} : in_data.bus_address;
    elements  = is_fifo ? 32'd1 : in_data.element_count;
    span_m1   = ({3'd0, elements} << sh) - 35'd1;
    // Last byte of the span; a carry or an all-ones end means it runs off the top.
    end_sum   = {1'b0, span_base} + {30'd0, span_m1};
    align_mask = 3'((4'd1 << sh) - 4'd1);
    misalign  = (span_base[2:0] & align_mask) != 3'd0;
    span_ok   = !code_bad && (in_data.element_count != 32'd0) && !misalign &&
                !end_sum[64] && !(&end_sum[63:0]);
    reg_max   = legacy_mode ? rbad_pkg::LEGACY_REG_MAX : rbad_pkg::ECAM_REG_MAX;
    too_high  = end_sum[63:0] > {52'd0, reg_max};
    pre_invalid = code_bad || (cfg_dev > rbad_pkg::DEV_MAX) || (cfg_func > rbad_pkg::FUNC_MAX);
    elem_bad  = {20'd0, in_data.element_index} >= in_data.element_count;
    // Fifo accesses repeat the first element's address.
    elem_sel  = is_fifo ? 12'd0 : in_data.element_index;
    elem_step = {3'd0, elem_sel} << sh;
    low8      = cfg_off[7:0] + elem_step[7:0];

    if (pre_invalid) begin
      cfg_status = rbad_pkg::ST_INVALID;
    end else if (!span_ok || too_high) begin
      cfg_status = rbad_pkg::ST_UNSUPPORTED;
    end else if (legacy_mode && elem_bad) begin
      cfg_status = rbad_pkg::ST_INVALID;
    end else begin
      cfg_status = rbad_pkg::ST_OK;
    end

    cmd_nxt              = '0;
    cmd_nxt.op           = in_data.op;
    cmd_nxt.window_index = in_data.window_index;
    cmd_nxt.window_en    = in_data.window_base <= in_data.window_limit;
    cmd_nxt.span_ok      = span_ok;
    cmd_nxt.cfg_status   = cfg_status;
    cmd_nxt.legacy       = legacy_mode;
    cmd_nxt.cf8          = rbad_pkg::CF8_ENABLE |
                           {8'd0, cfg_bus, cfg_dev[4:0], cfg_func[2:0], low8[7:2], 2'b00};
    cmd_nxt.port         = low8[1:0];
    unique case (in_data.op)
      rbad_pkg::OP_LOAD: begin
        cmd_nxt.addr     = in_data.window_base;
        cmd_nxt.end_addr = in_data.window_limit;
        cmd_nxt.aux      = in_data.window_offset;
      end
      rbad_pkg::OP_MEM, rbad_pkg::OP_IO: begin
        cmd_nxt.addr     = in_data.bus_address;
        cmd_nxt.end_addr = end_sum[63:0];
        cmd_nxt.aux      = 64'd0;
      end
      default: begin
        cmd_nxt.addr     = in_data.bus_address;
        cmd_nxt.end_addr = end_sum[63:0];
        cmd_nxt.aux      = {36'd0, cfg_bus, cfg_dev[4:0], cfg_func[2:0], cfg_off[11:0]};
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

endmodule

>>> src/rbad_queue.sv
module rbad_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rbad_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rbad_pkg::cmd_t pop_data
);

  localparam int PTR_W = $clog2(rbad_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(rbad_pkg::Q_DEPTH + 1);

  rbad_pkg::cmd_t   ent_r [rbad_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign push_ready = cnt_r != CNT_W'(rbad_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(rbad_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(rbad_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/rbad_back.sv
module rbad_back #(
  parameter int NUM_WINDOWS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  rbad_pkg::cmd_t      cmd_data,
  input  logic [63:0]         mmcfg_base,
  output logic                out_valid,
  input  logic                out_stall,
  output rbad_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(NUM_WINDOWS);

  // Window tables
  logic [63:0]            base_r   [NUM_WINDOWS];
  logic [63:0]            limit_r  [NUM_WINDOWS];
  logic [63:0]            offset_r [NUM_WINDOWS];
  logic [NUM_WINDOWS-1:0] en_r;

  // Lookup stage
  logic        s1_v_r;
  logic        s1_v_nxt;
  logic [1:0]  s1_op_r;
  logic [1:0]  s1_status_r;
  logic [1:0]  s1_status_nxt;
  logic [IDX_W-1:0] s1_sel_r;
  logic [IDX_W-1:0] s1_sel_nxt;
  logic        s1_legacy_r;
  logic [63:0] s1_addr_r;
  logic [63:0] s1_aux_r;
  logic [31:0] s1_cf8_r;
  logic [1:0]  s1_port_r;

  // Result register
  logic                out_valid_r;
  logic                out_valid_nxt;
  rbad_pkg::out_item_t out_r;
  rbad_pkg::out_item_t out_nxt;

  logic                   out_ready;
  logic                   s1_move;
  logic                   pop;
  logic                   load_ok;
  logic                   load_wr;
  logic                   bus_ok;
  logic [NUM_WINDOWS-1:0] hit;
  logic                   any_hit;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_move   = s1_v_r && out_ready;
  assign cmd_ready = !s1_v_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign load_ok   = {1'b0, cmd_data.window_index} < 4'(NUM_WINDOWS);
  assign load_wr   = pop && (cmd_data.op == rbad_pkg::OP_LOAD) && load_ok;
  assign bus_ok    = ({56'd0, cmd_data.addr[31:24]} >= base_r[0]) &&
                     ({56'd0, cmd_data.addr[31:24]} <= limit_r[0]);

  // Window 1 serves I/O, windows 2 and up serve memory.
  always_comb begin
    for (int i = 0; i < NUM_WINDOWS; i++) begin
      hit[i] = en_r[i] && (cmd_data.addr >= base_r[i]) && (cmd_data.end_addr <= limit_r[i]) &&
               (((cmd_data.op == rbad_pkg::OP_IO) && (i == 1)) ||
                ((cmd_data.op == rbad_pkg::OP_MEM) && (i >= 2)));
    end
    any_hit    = |hit;
    s1_sel_nxt = '0;
    for (int i = NUM_WINDOWS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        s1_sel_nxt = IDX_W'(i);
      end
    end
  end

  always_comb begin
    unique case (cmd_data.op)
      rbad_pkg::OP_LOAD: begin
        s1_status_nxt = load_ok ? rbad_pkg::ST_OK : rbad_pkg::ST_INVALID;
      end
      rbad_pkg::OP_MEM, rbad_pkg::OP_IO: begin
        s1_status_nxt = (cmd_data.span_ok && any_hit) ? rbad_pkg::ST_OK : rbad_pkg::ST_INVALID;
      end
      default: begin
        // A bus outside window 0 outranks every later config check.
        s1_status_nxt = bus_ok ? cmd_data.cfg_status : rbad_pkg::ST_INVALID;
      end
    endcase
  end

  always_comb begin
    if (pop) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = s1_status_r;
    if (s1_status_r == rbad_pkg::ST_OK) begin
      unique case (s1_op_r)
        rbad_pkg::OP_LOAD: begin
          out_nxt.target_address = 64'd0;
        end
        rbad_pkg::OP_MEM, rbad_pkg::OP_IO: begin
          out_nxt.target_address = s1_addr_r - offset_r[s1_sel_r];
        end
        default: begin
          if (s1_legacy_r) begin
            out_nxt.legacy_cycle     = 1'b1;
            out_nxt.cf8_word         = s1_cf8_r;
            out_nxt.data_port_offset = s1_port_r;
          end else begin
            out_nxt.target_address = mmcfg_base + s1_aux_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        base_r[i]   <= '1;
        limit_r[i]  <= '0;
        offset_r[i] <= '0;
      end
      en_r <= '0;
    end else if (load_wr) begin
      base_r[cmd_data.window_index[IDX_W-1:0]]   <= cmd_data.addr;
      limit_r[cmd_data.window_index[IDX_W-1:0]]  <= cmd_data.end_addr;
      offset_r[cmd_data.window_index[IDX_W-1:0]] <= cmd_data.aux;
      en_r[cmd_data.window_index[IDX_W-1:0]]     <= cmd_data.window_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r     <= cmd_data.op;
      s1_status_r <= s1_status_nxt;
      s1_sel_r    <= s1_sel_nxt;
      s1_legacy_r <= cmd_data.legacy;
      s1_addr_r   <= cmd_data.addr;
      s1_aux_r    <= cmd_data.aux;
      s1_cf8_r    <= cmd_data.cf8;
      s1_port_r   <= cmd_data.port;
    end
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_out_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r))
    else $error("result appeared without a request in the lookup stage");

  a_lookup_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_ready) |=> s1_v_r)
    else $error("lookup stage dropped a request while the result register was full");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != rbad_pkg::ST_OK) |->
      (out_r.target_address == 64'd0 && !out_r.legacy_cycle &&
       out_r.cf8_word == 32'd0 && out_r.data_port_offset == 2'd0))
    else $error("error result carries nonzero fields");

  a_legacy_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.legacy_cycle) |->
      (out_r.target_address == 64'd0 && out_r.cf8_word[31] && out_r.status == rbad_pkg::ST_OK))
    else $error("malformed CF8 cycle result");
`endif

endmodule

>>> src/root_bridge_address_decoder_top.sv
// Root bridge address decoder.
// Input channel (in_valid / in_stall / in_data): one request per item. A load
// writes one address window; a memory or I/O access is checked and translated
// through windows 1..NUM_WINDOWS-1; a config access yields an ECAM address or
// one CF8 word with its CFC data-port offset.
// Result channel (out_valid / out_stall / out_data): exactly one result per
// request, in request order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// index 0 is the ECAM base, index 1 selects legacy CF8/CFC config cycles.
// Write it only while no request is in flight.
// A request passes through the input register, the queue, the window lookup
// stage and the result register, in that order.
// Throughput: one request per cycle while out_stall is low; the window lookup
// stage runs once per request and sets the rate.
// Reset clears all windows to disabled, the ECAM base to zero and legacy mode
// off. A stalled result holds; requests keep entering until the two-entry
// queue between classifier and lookup fills, then in_stall rises.
module root_bridge_address_decoder_top #(
  parameter int NUM_WINDOWS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rbad_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rbad_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data
);

  logic [63:0]    mmcfg_base_r;
  logic           legacy_r;
  logic           cfg_wr;

  logic           f_valid;
  logic           f_ready;
  rbad_pkg::cmd_t f_data;
  logic           q_valid;
  logic           q_ready;
  rbad_pkg::cmd_t q_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mmcfg_base_r <= 64'd0;
      legacy_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rbad_pkg::CFG_MMCFG_BASE: mmcfg_base_r <= cfg_data;
        rbad_pkg::CFG_LEGACY:     legacy_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rbad_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .legacy_mode(legacy_r),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd_data   (f_data)
  );

  rbad_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_data),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  rbad_back #(
    .NUM_WINDOWS(NUM_WINDOWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_data),
    .mmcfg_base(mmcfg_base_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
